// ===== rtl/core/sewm_pkg.sv =====
// ----------------------------------------------------------------------------
// sewm_pkg
// Types and thresholds of the safety edge and wicket monitor.
// ----------------------------------------------------------------------------
`default_nettype none

package sewm_pkg;

    // Configuration register indexes
    localparam logic [1:0] CFG_EDGE_TYPE      = 2'd0;
    localparam logic [1:0] CFG_WICKET_MODE    = 2'd1;
    localparam logic [1:0] CFG_WICKET_LEARNED = 2'd2;

    // Edge types
    localparam logic [1:0] EDGE_RESISTIVE = 2'd0;
    localparam logic [1:0] EDGE_8K2       = 2'd1;
    localparam logic [1:0] EDGE_OPTICAL   = 2'd2;

    // Wicket modes
    localparam logic [1:0] WK_MODE_OFF     = 2'd0;
    localparam logic [1:0] WK_MODE_LEARNED = 2'd1;
    localparam logic [1:0] WK_MODE_NC      = 2'd2;

    // Counters
    localparam int unsigned TOGGLE_PERIOD_I = 600;
    localparam int unsigned SETTLE_RELOAD_I = 60;
    localparam logic [9:0]  TOGGLE_PERIOD   = 10'(TOGGLE_PERIOD_I);
    localparam logic [9:0]  TOGGLE_HALF     = 10'(TOGGLE_PERIOD_I / 2);
    localparam logic [5:0]  SETTLE_RELOAD   = 6'(SETTLE_RELOAD_I);

    // Edge thresholds (ADC counts)
    localparam logic [11:0] SUPPLY_LOW      = 12'd1489;
    localparam logic [11:0] EDGE_TEST_LOW   = 12'd1241;
    localparam logic [11:0] EDGE_RES_ACTIVE = 12'd3227;
    localparam logic [11:0] EDGE_BAND_LOW   = 12'd2730;
    localparam logic [11:0] EDGE_BAND_HIGH  = 12'd3600;
    localparam logic [11:0] EDGE_8K2_ACTIVE = 12'd3662;

    // Wicket thresholds (ADC counts)
    localparam logic [11:0] WK_MIN          = 12'd1135;
    localparam logic [11:0] WK_TEST_OPEN    = 12'd1055;
    localparam logic [11:0] WK_TOL          = 12'd186;
    localparam logic [11:0] WK_TYPE_F       = 12'd1451;
    localparam logic [11:0] WK_TYPE_F_LOW   = 12'(1451 - 186);
    localparam logic [11:0] WK_TYPE_F_HIGH  = 12'(1451 + 186);
    localparam logic [11:0] WK_SHORT_BAND   = 12'd3500;
    localparam logic [11:0] WK_SHORT_TOP    = 12'd4001;
    localparam logic [11:0] WK_NC_CLOSED    = 12'd3103;

    typedef enum logic [1:0] {
        WK_OK    = 2'd0,
        WK_OPEN  = 2'd1,
        WK_SHORT = 2'd2
    } t_wicket_status;

    typedef struct packed {
        logic [11:0] edge_sample;
        logic [11:0] wicket_sample;
        logic        self_test;
        logic        run_active;
        logic        optical_present;
        logic        encoder_error;
        logic        end_limit;
    } t_in_item;

    typedef struct packed {
        logic           edge_active;
        logic           edge_error;
        logic           supply_fail_high;
        logic           supply_fail_low;
        t_wicket_status wicket_status;
        logic           wicket_range_fault;
    } t_out_item;

endpackage

`default_nettype wire

// ===== rtl/core/safety_edge_wicket_monitor.sv =====
// ----------------------------------------------------------------------------
// safety_edge_wicket_monitor
// Classifies safety edge and wicket ADC sample pairs, tracks supply failure.
// ----------------------------------------------------------------------------
//  channel | direction | handshake               | payload
//  in      | input     | i_in_valid / o_in_stall  | i_in_data  (t_in_item)
//  out     | output    | o_out_valid / i_out_stall| o_out_data (t_out_item)
//  cfg     | input     | i_cfg_we                 | i_cfg_index, i_cfg_data
//
//  One sample pair per cycle unless the output stalls. A pair is taken into the
//  input register, then classified in one pass into the result register.
//  Reset (synchronous, active low) clears configuration, valid flags and monitor state; data registers are not reset.
//  While the result is stalled, one more pair is held in the input register;
//  the input stalls only when both registers are full.
// ----------------------------------------------------------------------------
`default_nettype none

module safety_edge_wicket_monitor (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire sewm_pkg::t_in_item i_in_data,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output sewm_pkg::t_out_item     o_out_data,
    input  wire logic               i_cfg_we,
    input  wire logic [1:0]         i_cfg_index,
    input  wire logic [11:0]        i_cfg_data
);

    // configuration
    logic [1:0]  r_edge_type;
    logic [1:0]  r_wicket_mode;
    logic [11:0] r_wicket_learned;

    // pipeline
    logic                r_in_valid;
    sewm_pkg::t_in_item  r_in;
    logic                r_out_valid;
    sewm_pkg::t_out_item r_out;
    logic                advance;

    // monitor state
    logic [9:0]               r_toggle_count, n_toggle_count;
    logic [5:0]               r_settle_count, n_settle_count;
    logic                     r_edge_flag, n_edge_flag;
    logic                     r_error_flag, n_error_flag;
    logic                     r_fail_high, n_fail_high;
    logic                     r_fail_low, n_fail_low;
    sewm_pkg::t_wicket_status r_wicket_state, n_wicket_state;
    logic                     r_range_flag, n_range_flag;

    // wicket window sums, one bit wider than the sample
    logic [12:0] w_plus_tol;
    logic [12:0] l_plus_tol;
    logic        w_in_window;
    logic        learned_type_f;

    assign advance     = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall  = r_in_valid && !advance;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign w_plus_tol     = {1'b0, r_in.wicket_sample} + {1'b0, sewm_pkg::WK_TOL};
    assign l_plus_tol     = {1'b0, r_wicket_learned} + {1'b0, sewm_pkg::WK_TOL};
    assign w_in_window    = (w_plus_tol > {1'b0, r_wicket_learned})
                         && ({1'b0, r_in.wicket_sample} < l_plus_tol);
    assign learned_type_f = (r_wicket_learned > sewm_pkg::WK_TYPE_F_LOW)
                         && (r_wicket_learned < sewm_pkg::WK_TYPE_F_HIGH);

    always_comb begin
        logic [11:0] s;
        logic [11:0] w;
        logic        test;
        logic        run;
        logic        opt;

        s    = r_in.edge_sample;
        w    = r_in.wicket_sample;
        test = r_in.self_test;
        run  = r_in.run_active;
        opt  = r_in.optical_present;

        n_toggle_count = r_toggle_count;
        n_settle_count = r_settle_count;
        n_edge_flag    = r_edge_flag;
        n_error_flag   = r_error_flag;
        n_fail_high    = r_fail_high;
        n_fail_low     = r_fail_low;
        n_wicket_state = r_wicket_state;
        n_range_flag   = r_range_flag;

        if (n_settle_count != 6'd0) begin
            n_settle_count = n_settle_count - 6'd1;
        end

        // supply dip: alternate the sticky fail flags
        if (!test && s < sewm_pkg::SUPPLY_LOW) begin
            if (n_toggle_count != 10'd0) begin
                n_toggle_count = n_toggle_count - 10'd1;
            end else begin
                n_toggle_count = sewm_pkg::TOGGLE_PERIOD;
            end
            n_fail_high = n_toggle_count > sewm_pkg::TOGGLE_HALF;
            n_fail_low  = !(n_toggle_count > sewm_pkg::TOGGLE_HALF);
        end

        // edge classification; a setup error forces the edge active
        case (r_edge_type)
            sewm_pkg::EDGE_RESISTIVE: begin
                if (test) begin
                    n_edge_flag = s < sewm_pkg::EDGE_TEST_LOW;
                end else begin
                    n_edge_flag = s < sewm_pkg::EDGE_RES_ACTIVE;
                    if (s >= sewm_pkg::EDGE_BAND_LOW && s <= sewm_pkg::EDGE_BAND_HIGH) begin
                        if (n_settle_count == 6'd0) begin
                            n_error_flag = 1'b1;
                            n_edge_flag  = 1'b1;
                        end
                    end else begin
                        n_error_flag   = 1'b0;
                        n_settle_count = sewm_pkg::SETTLE_RELOAD;
                    end
                    if (run && (opt || s < sewm_pkg::EDGE_RES_ACTIVE)) begin
                        n_error_flag = 1'b1;
                        n_edge_flag  = 1'b1;
                    end
                end
            end
            sewm_pkg::EDGE_8K2: begin
                if (test) begin
                    n_edge_flag = s < sewm_pkg::EDGE_TEST_LOW;
                end else begin
                    n_edge_flag = s > sewm_pkg::EDGE_8K2_ACTIVE;
                    if (s < sewm_pkg::EDGE_BAND_LOW) begin
                        if (n_settle_count == 6'd0) begin
                            n_error_flag = 1'b1;
                            n_edge_flag  = 1'b1;
                        end
                    end else begin
                        n_error_flag   = 1'b0;
                        n_settle_count = sewm_pkg::SETTLE_RELOAD;
                    end
                    if (run && (s > sewm_pkg::EDGE_8K2_ACTIVE
                                || s < sewm_pkg::EDGE_BAND_LOW || opt)) begin
                        n_error_flag = 1'b1;
                        n_edge_flag  = 1'b1;
                    end
                end
            end
            sewm_pkg::EDGE_OPTICAL: begin
                if (s < sewm_pkg::EDGE_BAND_LOW) begin
                    n_error_flag   = 1'b0;
                    n_settle_count = sewm_pkg::SETTLE_RELOAD;
                end else begin
                    n_error_flag = 1'b1;
                    n_edge_flag  = 1'b1;
                end
            end
            default: begin
                // unused edge type: flags hold
            end
        endcase

        // wicket classification
        if (!run && r_in.encoder_error && w > sewm_pkg::WK_MIN && r_in.end_limit) begin
            n_wicket_state = sewm_pkg::WK_OK;
            n_range_flag   = 1'b0;
        end else if (test) begin
            n_wicket_state = (w < sewm_pkg::WK_TEST_OPEN) ? sewm_pkg::WK_OPEN : sewm_pkg::WK_OK;
        end else begin
            n_range_flag = 1'b0;
            case (r_wicket_mode)
                sewm_pkg::WK_MODE_LEARNED: begin
                    if (w < sewm_pkg::WK_MIN) begin
                        n_range_flag   = 1'b1;
                        n_wicket_state = sewm_pkg::WK_OPEN;
                    end else if (learned_type_f) begin
                        if (w < sewm_pkg::WK_SHORT_BAND && w > sewm_pkg::WK_TYPE_F_HIGH) begin
                            n_wicket_state = sewm_pkg::WK_SHORT;
                        end else if (w > sewm_pkg::WK_SHORT_TOP) begin
                            n_wicket_state = sewm_pkg::WK_SHORT;
                        end else if (w_in_window) begin
                            n_wicket_state = sewm_pkg::WK_OK;
                        end else begin
                            n_wicket_state = sewm_pkg::WK_OPEN;
                        end
                    end else if (w_in_window) begin
                        n_wicket_state = sewm_pkg::WK_OK;
                    end else if ({1'b0, w} >= l_plus_tol) begin
                        n_wicket_state = sewm_pkg::WK_SHORT;
                    end else begin
                        n_wicket_state = sewm_pkg::WK_OPEN;
                    end
                end
                sewm_pkg::WK_MODE_NC: begin
                    if (w > sewm_pkg::WK_NC_CLOSED) begin
                        n_wicket_state = sewm_pkg::WK_OK;
                    end else begin
                        n_range_flag   = 1'b1;
                        n_wicket_state = sewm_pkg::WK_OPEN;
                    end
                end
                default: begin
                    // no wicket check: status holds
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_edge_type      <= sewm_pkg::EDGE_RESISTIVE;
            r_wicket_mode    <= sewm_pkg::WK_MODE_OFF;
            r_wicket_learned <= 12'd0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                sewm_pkg::CFG_EDGE_TYPE:      r_edge_type      <= i_cfg_data[1:0];
                sewm_pkg::CFG_WICKET_MODE:    r_wicket_mode    <= i_cfg_data[1:0];
                sewm_pkg::CFG_WICKET_LEARNED: r_wicket_learned <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
            r_toggle_count <= 10'd0;
            r_settle_count <= 6'd0;
            r_edge_flag    <= 1'b0;
            r_error_flag   <= 1'b0;
            r_fail_high    <= 1'b0;
            r_fail_low     <= 1'b0;
            r_wicket_state <= sewm_pkg::WK_OK;
            r_range_flag   <= 1'b0;
        end else begin
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid    <= 1'b1;
                r_toggle_count <= n_toggle_count;
                r_settle_count <= n_settle_count;
                r_edge_flag    <= n_edge_flag;
                r_error_flag   <= n_error_flag;
                r_fail_high    <= n_fail_high;
                r_fail_low     <= n_fail_low;
                r_wicket_state <= n_wicket_state;
                r_range_flag   <= n_range_flag;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in <= i_in_data;
        end
        if (advance) begin
            r_out.edge_active        <= n_edge_flag;
            r_out.edge_error         <= n_error_flag;
            r_out.supply_fail_high   <= n_fail_high;
            r_out.supply_fail_low    <= n_fail_low;
            r_out.wicket_status      <= n_wicket_state;
            r_out.wicket_range_fault <= n_range_flag;
        end
    end

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_fail_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_fail_high && r_fail_low))
        else $error("both supply fail flags set");

    a_held_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !advance) |=> (r_in_valid && $stable(r_in)))
        else $error("held sample pair lost");

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && r_out_valid && i_out_stall))
        else $error("input stalled with room free");

    a_settle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_settle_count <= sewm_pkg::SETTLE_RELOAD)
        else $error("settle counter above reload");

    a_toggle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_toggle_count <= sewm_pkg::TOGGLE_PERIOD)
        else $error("toggle counter above period");

endmodule

`default_nettype wire
